>>> rtl/core/lfvp_pkg.sv
// Shared types and codes of the length framed varint field parser
package lfvp_pkg;

   // Register widths and reset value
   localparam int unsigned FRAME_LEN_W = 27;
   localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LENGTH_RESET = 27'd67108864;

   // Result kinds
   localparam logic [1:0] KIND_FIELD_BYTE = 2'd0;
   localparam logic [1:0] KIND_ACCEPT     = 2'd1;
   localparam logic [1:0] KIND_REJECT     = 2'd2;

   // Reject reasons
   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_OVERSIZE      = 3'd1;
   localparam logic [2:0] ERR_LONG_VARINT   = 3'd2;
   localparam logic [2:0] ERR_WIRE_TYPE     = 3'd3;
   localparam logic [2:0] ERR_OVERRUN       = 3'd4;
   localparam logic [2:0] ERR_TRUNC_VARINT  = 3'd5;
   localparam logic [2:0] ERR_NO_PAYLOAD    = 3'd6;

   // Tracked field codes; bit 2 set means the field is not emitted
   localparam logic [2:0] FIELD_SOURCE      = 3'd0;
   localparam logic [2:0] FIELD_DESTINATION = 3'd1;
   localparam logic [2:0] FIELD_NAMESPACE   = 3'd2;
   localparam logic [2:0] FIELD_PAYLOAD     = 3'd3;
   localparam logic [2:0] FIELD_NONE        = 3'd4;

   // Protobuf wire types
   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_LENGTH = 3'd2;

   // Index of the last byte a varint may take
   localparam logic [3:0] VARINT_LAST_BYTE = 4'd9;

   // One result transaction
   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] field_sel;
      logic [7:0] out_byte;
      logic       field_end;
      logic [2:0] error_code;
   } result_type;

   // Results produced by one parsed byte
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

>>> rtl/core/lfvp_parser.sv
// Frame and protobuf field state machine, one byte per enabled cycle
module lfvp_parser
   import lfvp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             in_byte,
   input  logic [FRAME_LEN_W-1:0] max_frame_length,
   output push_type               push
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TAG,
      PH_VALUE,
      PH_LENGTH,
      PH_DATA,
      PH_DRAIN
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [1:0]             header_count_ff, header_count_in;
   logic [FRAME_LEN_W-1:0] body_remaining_ff, body_remaining_in;
   logic [63:0]            accum_ff, accum_in;
   logic [3:0]             shift_ff, shift_in;
   logic [2:0]             field_ff, field_in;
   logic [FRAME_LEN_W-1:0] field_remaining_ff, field_remaining_in;
   logic                   payload_nonempty_ff, payload_nonempty_in;
   logic [2:0]             error_ff, error_in;

   // Varint byte merge, shared by tag, value and length phases
   logic [5:0]             shift_amt;
   logic [63:0]            acc_or;
   logic                   vi_done;
   logic                   vi_long;
   logic [31:0]            header_word;
   logic [FRAME_LEN_W-1:0] body_dec;
   logic [FRAME_LEN_W-1:0] field_dec;
   logic [2:0]             tag_field;

   assign shift_amt   = ({2'b00, shift_ff} << 3) - {2'b00, shift_ff};
   assign acc_or      = accum_ff | ({57'd0, in_byte[6:0]} << shift_amt);
   assign vi_done     = ~in_byte[7];
   assign vi_long     = in_byte[7] & (shift_ff >= VARINT_LAST_BYTE);
   assign header_word = {accum_ff[23:0], in_byte};
   assign body_dec    = body_remaining_ff - 1'b1;
   assign field_dec   = field_remaining_ff - 1'b1;

   // Field number of a finished tag; high bits set never alias a tracked field
   always_comb begin
      tag_field = FIELD_NONE;
      if (acc_or[63:6] == 58'd0) begin
         unique case (acc_or[5:3])
            3'd2:    tag_field = FIELD_SOURCE;
            3'd3:    tag_field = FIELD_DESTINATION;
            3'd4:    tag_field = FIELD_NAMESPACE;
            3'd6:    tag_field = FIELD_PAYLOAD;
            default: tag_field = FIELD_NONE;
         endcase
      end
   end

   // Next state and results for the byte in hand
   always_comb begin
      result_type res_field;
      result_type res_verdict;
      logic       has_field;
      logic [2:0] verdict_err;

      phase_in            = phase_ff;
      header_count_in     = header_count_ff;
      body_remaining_in   = body_remaining_ff;
      accum_in            = accum_ff;
      shift_in            = shift_ff;
      field_in            = field_ff;
      field_remaining_in  = field_remaining_ff;
      payload_nonempty_in = payload_nonempty_ff;
      error_in            = error_ff;
      res_field           = '0;
      res_verdict         = '0;
      has_field           = 1'b0;
      verdict_err         = ERR_NONE;
      push                = '0;

      if (fire) begin
         if (phase_ff == PH_HEADER) begin
            // Big-endian length header
            header_count_in = header_count_ff + 1'b1;
            accum_in        = {32'd0, header_word};
            if (header_count_ff == 2'd3) begin
               accum_in            = '0;
               shift_in            = '0;
               field_in            = FIELD_NONE;
               field_remaining_in  = '0;
               payload_nonempty_in = 1'b0;
               error_in            = ERR_NONE;
               res_verdict.kind    = KIND_REJECT;
               if (header_word > {5'd0, max_frame_length}) begin
                  res_verdict.error_code = ERR_OVERSIZE;
                  push.count             = 2'd1;
               end else if (header_word == 32'd0) begin
                  res_verdict.error_code = ERR_NO_PAYLOAD;
                  push.count             = 2'd1;
               end else begin
                  body_remaining_in = header_word[FRAME_LEN_W-1:0];
                  phase_in          = PH_TAG;
               end
               push.first = res_verdict;
            end
         end else begin
            body_remaining_in = body_dec;
            unique case (phase_ff) inside
               PH_TAG, PH_VALUE, PH_LENGTH: begin
                  if (vi_long) begin
                     accum_in = acc_or;
                     error_in = ERR_LONG_VARINT;
                     phase_in = PH_DRAIN;
                  end else if (vi_done) begin
                     accum_in = '0;
                     shift_in = '0;
                     if (phase_ff == PH_TAG) begin
                        field_in = tag_field;
                        if (acc_or[2:0] == WIRE_VARINT) begin
                           phase_in = PH_VALUE;
                        end else if (acc_or[2:0] == WIRE_LENGTH) begin
                           phase_in = PH_LENGTH;
                        end else begin
                           error_in = ERR_WIRE_TYPE;
                           phase_in = PH_DRAIN;
                        end
                     end else if (phase_ff == PH_VALUE) begin
                        phase_in = PH_TAG;
                     end else if (acc_or > {37'd0, body_dec}) begin
                        error_in = ERR_OVERRUN;
                        phase_in = PH_DRAIN;
                     end else begin
                        if (field_ff == FIELD_PAYLOAD) begin
                           payload_nonempty_in = (acc_or != 64'd0);
                        end
                        if (acc_or == 64'd0) begin
                           phase_in = PH_TAG;
                        end else begin
                           field_remaining_in = acc_or[FRAME_LEN_W-1:0];
                           phase_in           = PH_DATA;
                        end
                     end
                  end else begin
                     accum_in = acc_or;
                     shift_in = shift_ff + 1'b1;
                  end
               end
               PH_DATA: begin
                  if (field_ff != FIELD_NONE) begin
                     has_field           = 1'b1;
                     res_field.kind      = KIND_FIELD_BYTE;
                     res_field.field_sel = field_ff[1:0];
                     res_field.out_byte  = in_byte;
                     res_field.field_end = (field_remaining_ff == 27'd1);
                  end
                  field_remaining_in = field_dec;
                  if (field_dec == '0) begin
                     phase_in = PH_TAG;
                  end
               end
               default: begin
               end
            endcase

            // Verdict on the last body byte
            if (body_dec == '0) begin
               verdict_err = error_in;
               if (verdict_err == ERR_NONE) begin
                  if (!(phase_in == PH_TAG && shift_in == 4'd0)) begin
                     verdict_err = ERR_TRUNC_VARINT;
                  end else if (!payload_nonempty_in) begin
                     verdict_err = ERR_NO_PAYLOAD;
                  end
               end
               res_verdict.kind       = (verdict_err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
               res_verdict.error_code = verdict_err;
               phase_in               = PH_HEADER;
               header_count_in        = '0;
               accum_in               = '0;
               shift_in               = '0;
               field_in               = FIELD_NONE;
               field_remaining_in     = '0;
               payload_nonempty_in    = 1'b0;
               error_in               = ERR_NONE;
            end

            // Pack up to two results, field byte first
            if (has_field) begin
               push.first  = res_field;
               push.second = res_verdict;
               push.count  = (body_dec == '0) ? 2'd2 : 2'd1;
            end else begin
               push.first  = res_verdict;
               push.count  = (body_dec == '0) ? 2'd1 : 2'd0;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_HEADER;
         header_count_ff     <= '0;
         body_remaining_ff   <= '0;
         accum_ff            <= '0;
         shift_ff            <= '0;
         field_ff            <= FIELD_NONE;
         field_remaining_ff  <= '0;
         payload_nonempty_ff <= 1'b0;
         error_ff            <= ERR_NONE;
      end else begin
         phase_ff            <= phase_in;
         header_count_ff     <= header_count_in;
         body_remaining_ff   <= body_remaining_in;
         accum_ff            <= accum_in;
         shift_ff            <= shift_in;
         field_ff            <= field_in;
         field_remaining_ff  <= field_remaining_in;
         payload_nonempty_ff <= payload_nonempty_in;
         error_ff            <= error_in;
      end
   end

endmodule

>>> rtl/core/lfvp_rsp_queue.sv
// Four-entry result queue, up to two pushes and one pop per cycle
module lfvp_rsp_queue
   import lfvp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] wr_next;

   // Room for two more results before the next byte is parsed
   assign room      = (count_ff < 3'd3);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign wr_next   = wr_ptr_ff + 2'd1;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   // Result storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   // Queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/length_framed_varint_field_parser_unit.sv
// Top level of the length framed varint field parser
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | req_in_byte
//   rsp     | out       | rsp_valid/stall    | rsp_kind, rsp_field_sel, rsp_out_byte,
//           |           |                    | rsp_field_end, rsp_error_code
//   csr     | in        | csr_valid/ready    | csr_max_frame_length
//
// One byte per cycle sustained while the queue has room. An accepted byte waits in
// the input register until parsed; results are offered one per cycle unless stalled.
// A byte that ends a field and its frame gives two results; the result queue
// holds four, and the input register stalls while fewer than two slots are free.
// Reset is synchronous and clears the state machine, queue and register to defaults.
// The csr write channel is always ready.
module length_framed_varint_field_parser_unit
   import lfvp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [1:0]             rsp_field_sel,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_field_end,
   output logic [2:0]             rsp_error_code,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [FRAME_LEN_W-1:0] csr_max_frame_length
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic [FRAME_LEN_W-1:0] max_len_ff;
   logic                   room;
   logic                   advance;
   logic                   req_take;
   push_type               push;
   result_type             rsp_data;

   // Input register handshake
   assign advance     = in_valid_ff & room;
   assign req_stall   = in_valid_ff & ~room;
   assign req_take    = req_valid & ~req_stall;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // Frame length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_FRAME_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_frame_length;
      end
   end

   lfvp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .fire             (advance),
      .in_byte          (in_byte_ff),
      .max_frame_length (max_len_ff),
      .push             (push)
   );

   lfvp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Result fields
   assign rsp_kind       = rsp_data.kind;
   assign rsp_field_sel  = rsp_data.field_sel;
   assign rsp_out_byte   = rsp_data.out_byte;
   assign rsp_field_end  = rsp_data.field_end;
   assign rsp_error_code = rsp_data.error_code;

endmodule

>>> tb/sv/lfvp_result_checker.sv
// Checker that predicts the parser's results from the byte stream and compares them
module lfvp_result_checker
   import lfvp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_kind,
   input  logic [1:0]             rsp_field_sel,
   input  logic [7:0]             rsp_out_byte,
   input  logic                   rsp_field_end,
   input  logic [2:0]             rsp_error_code,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [FRAME_LEN_W-1:0] csr_max_frame_length,
   output int                     fail_count,
   output int                     outstanding,
   output int                     field_results,
   output int                     accept_results,
   output int                     reject_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PS_HEADER, PS_TAG, PS_VALUE, PS_LENGTH, PS_DATA, PS_DRAIN
   } parse_state_e;

   typedef enum int {VI_MORE, VI_DONE, VI_TOO_LONG} varint_status_e;

   // Shadow of the register and the parser state
   logic [FRAME_LEN_W-1:0] frame_limit;
   parse_state_e           pstate;
   int unsigned            hdr_bytes;
   logic [FRAME_LEN_W-1:0] body_left;
   logic [63:0]            vacc;
   logic [3:0]             vshift;
   logic [2:0]             cur_field;
   logic [FRAME_LEN_W-1:0] field_left;
   logic                   payload_seen;
   logic [2:0]             err_latch;

   result_type expected_results[$];

   int fails   = 0;
   int pending = 0;
   int n_field = 0;
   int n_acc   = 0;
   int n_rej   = 0;

   assign fail_count     = fails;
   assign outstanding    = pending;
   assign field_results  = n_field;
   assign accept_results = n_acc;
   assign reject_results = n_rej;

   task automatic queue_result(input logic [1:0] k, input logic [1:0] sel,
                               input logic [7:0] b, input logic e, input logic [2:0] err);
      expected_results.push_back({k, sel, b, e, err});
   endtask

   task automatic clear_frame();
      vacc         = '0;
      vshift       = '0;
      cur_field    = FIELD_NONE;
      field_left   = '0;
      payload_seen = 1'b0;
      err_latch    = ERR_NONE;
   endtask

   // Accumulate one base-128 byte; the tenth byte may not continue
   function automatic varint_status_e take_varint(input logic [7:0] b);
      vacc = vacc | (64'(b[6:0]) << (7 * vshift));
      if (!b[7]) return VI_DONE;
      if (vshift >= VARINT_LAST_BYTE) return VI_TOO_LONG;
      vshift = vshift + 1'b1;
      return VI_MORE;
   endfunction

   function automatic logic [2:0] field_code(input logic [63:0] num);
      case (num)
         64'd2:   return FIELD_SOURCE;
         64'd3:   return FIELD_DESTINATION;
         64'd4:   return FIELD_NAMESPACE;
         64'd6:   return FIELD_PAYLOAD;
         default: return FIELD_NONE;
      endcase
   endfunction

   // Advance the parser by one byte and queue the results it causes
   task automatic predict_byte(input logic [7:0] b);
      logic [31:0]    hdr_len;
      logic [63:0]    tag;
      logic [63:0]    vlen;
      logic [2:0]     err;
      varint_status_e st;
      if (pstate == PS_HEADER) begin
         vacc = {32'd0, vacc[23:0], b};
         hdr_bytes++;
         if (hdr_bytes == 4) begin
            hdr_len   = vacc[31:0];
            hdr_bytes = 0;
            clear_frame();
            if (hdr_len > frame_limit) begin
               queue_result(KIND_REJECT, 2'd0, 8'd0, 1'b0, ERR_OVERSIZE);
            end else if (hdr_len == 0) begin
               queue_result(KIND_REJECT, 2'd0, 8'd0, 1'b0, ERR_NO_PAYLOAD);
            end else begin
               body_left = hdr_len[FRAME_LEN_W-1:0];
               pstate    = PS_TAG;
            end
         end
      end else begin
         body_left = body_left - 1'b1;
         case (pstate)
            PS_TAG: begin
               st = take_varint(b);
               if (st == VI_TOO_LONG) begin
                  err_latch = ERR_LONG_VARINT;
                  pstate    = PS_DRAIN;
               end else if (st == VI_DONE) begin
                  tag       = vacc;
                  vacc      = '0;
                  vshift    = '0;
                  cur_field = field_code(tag >> 3);
                  if (tag[2:0] == WIRE_VARINT) begin
                     pstate = PS_VALUE;
                  end else if (tag[2:0] == WIRE_LENGTH) begin
                     pstate = PS_LENGTH;
                  end else begin
                     err_latch = ERR_WIRE_TYPE;
                     pstate    = PS_DRAIN;
                  end
               end
            end
            PS_VALUE: begin
               st = take_varint(b);
               if (st == VI_TOO_LONG) begin
                  err_latch = ERR_LONG_VARINT;
                  pstate    = PS_DRAIN;
               end else if (st == VI_DONE) begin
                  vacc   = '0;
                  vshift = '0;
                  pstate = PS_TAG;
               end
            end
            PS_LENGTH: begin
               st = take_varint(b);
               if (st == VI_TOO_LONG) begin
                  err_latch = ERR_LONG_VARINT;
                  pstate    = PS_DRAIN;
               end else if (st == VI_DONE) begin
                  vlen   = vacc;
                  vacc   = '0;
                  vshift = '0;
                  if (vlen > 64'(body_left)) begin
                     err_latch = ERR_OVERRUN;
                     pstate    = PS_DRAIN;
                  end else begin
                     // last payload occurrence decides
                     if (cur_field == FIELD_PAYLOAD) payload_seen = (vlen != 0);
                     if (vlen == 0) begin
                        pstate = PS_TAG;
                     end else begin
                        field_left = vlen[FRAME_LEN_W-1:0];
                        pstate     = PS_DATA;
                     end
                  end
               end
            end
            PS_DATA: begin
               if (cur_field < FIELD_NONE)
                  queue_result(KIND_FIELD_BYTE, cur_field[1:0], b, field_left == 1, ERR_NONE);
               field_left = field_left - 1'b1;
               if (field_left == 0) pstate = PS_TAG;
            end
            default: ;
         endcase

         // frame verdict on the last body byte
         if (body_left == 0) begin
            err = err_latch;
            if (err == ERR_NONE) begin
               if (!(pstate == PS_TAG && vshift == 0)) err = ERR_TRUNC_VARINT;
               else if (!payload_seen) err = ERR_NO_PAYLOAD;
            end
            if (err == ERR_NONE) queue_result(KIND_ACCEPT, 2'd0, 8'd0, 1'b0, ERR_NONE);
            else queue_result(KIND_REJECT, 2'd0, 8'd0, 1'b0, err);
            pstate    = PS_HEADER;
            hdr_bytes = 0;
            clear_frame();
         end
      end
   endtask

   // Compare one result transaction against the oldest expectation
   task automatic check_result();
      result_type got;
      result_type want;
      got = {rsp_kind, rsp_field_sel, rsp_out_byte, rsp_field_end, rsp_error_code};
      if (expected_results.size() == 0) begin
         if (fails < 10)
            $display("unexpected result: kind %0d sel %0d byte %02h end %0b err %0d",
                     got.kind, got.field_sel, got.out_byte, got.field_end, got.error_code);
         fails++;
      end else begin
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.field_sel !== want.field_sel ||
             got.out_byte !== want.out_byte || got.field_end !== want.field_end ||
             got.error_code !== want.error_code) begin
            if (fails < 10)
               $display("mismatch: expected kind %0d sel %0d byte %02h end %0b err %0d, %s",
                        want.kind, want.field_sel, want.out_byte, want.field_end,
                        want.error_code, $sformatf("got kind %0d sel %0d byte %02h end %0b err %0d",
                        got.kind, got.field_sel, got.out_byte, got.field_end, got.error_code));
            fails++;
         end
         if (want.kind == KIND_FIELD_BYTE) n_field++;
         else if (want.kind == KIND_ACCEPT) n_acc++;
         else n_rej++;
      end
   endtask

   // Watch all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         frame_limit = MAX_FRAME_LENGTH_RESET;
         pstate      = PS_HEADER;
         hdr_bytes   = 0;
         body_left   = '0;
         clear_frame();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_valid && csr_ready) frame_limit = csr_max_frame_length;
         if (req_valid && !req_stall) predict_byte(req_in_byte);
      end
      pending = expected_results.size();
   end

endmodule

>>> tb/sv/length_framed_varint_field_parser_unit_test.sv
// Testbench top: framed byte stimulus, idling, register settings and the verdict
module length_framed_varint_field_parser_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lfvp_pkg::*;

   localparam int QUIET_LIMIT = 400;
   localparam int PHASE_BYTES = 207;
   localparam int N_SETTINGS  = 7;
   // zero body, oversize header, one-byte payload accept, bad wire type
   localparam logic [159:0] DIRECTED_BYTES =
      160'h00000000_FFFFFFFF_00000003_3201AB_00000001_0B;

   typedef enum int {
      FK_VARINT, FK_TRACKED, FK_OTHER, FK_BAD_WIRE, FK_LONG_VARINT, FK_OVERRUN
   } field_kind_e;

   logic                   clock                = 1'b0;
   logic                   reset                = 1'b1;
   logic                   req_valid            = 1'b0;
   logic [7:0]             req_in_byte          = 8'd0;
   logic                   rsp_stall            = 1'b0;
   logic                   csr_valid            = 1'b0;
   logic [FRAME_LEN_W-1:0] csr_max_frame_length = MAX_FRAME_LENGTH_RESET;
   logic                   req_stall;
   logic                   rsp_valid;
   logic [1:0]             rsp_kind;
   logic [1:0]             rsp_field_sel;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_field_end;
   logic [2:0]             rsp_error_code;
   logic                   csr_ready;

   int fail_count;
   int outstanding;
   int field_results;
   int accept_results;
   int reject_results;

   // Stimulus bookkeeping
   logic [7:0]             frame_q[$];
   logic [7:0]             body_q[$];
   logic [FRAME_LEN_W-1:0] limit_shadow = MAX_FRAME_LENGTH_RESET;
   bit                     idle_on      = 1'b0;
   int                     bytes_sent   = 0;
   int                     frames_sent  = 0;
   int                     stall_left   = 0;

   always #1 clock = ~clock;

   length_framed_varint_field_parser_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_field_sel        (rsp_field_sel),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_field_end        (rsp_field_end),
      .rsp_error_code       (rsp_error_code),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length)
   );

   lfvp_result_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_field_sel        (rsp_field_sel),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_field_end        (rsp_field_end),
      .rsp_error_code       (rsp_error_code),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length),
      .fail_count           (fail_count),
      .outstanding          (outstanding),
      .field_results        (field_results),
      .accept_results       (accept_results),
      .reject_results       (reject_results)
   );

   // Result side stalls in random bursts, which start only while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: ends the run after too many cycles without any transaction
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // One byte transaction; called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_queue();
      while (frame_q.size() != 0) send_byte(frame_q.pop_front());
   endtask

   // Let the pipeline run dry before touching the register
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limit(input logic [FRAME_LEN_W-1:0] v);
      csr_valid            <= 1'b1;
      csr_max_frame_length <= v;
      limit_shadow = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int pad_choice();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
   endfunction

   function automatic logic [63:0] tracked_num();
      case ($urandom_range(0, 3))
         0:       return 64'd2;
         1:       return 64'd3;
         2:       return 64'd4;
         default: return 64'd6;
      endcase
   endfunction

   // Field number: tracked, small, large, or a large one whose low bits alias a tracked one
   function automatic logic [63:0] pick_num();
      case ($urandom_range(0, 3))
         0:       return tracked_num();
         1:       return 64'($urandom_range(0, 15));
         2:       return 64'($urandom);
         default: return tracked_num() + (64'd1 << $urandom_range(3, 58));
      endcase
   endfunction

   // Base-128 encoding, optionally padded with redundant continuation bytes
   task automatic push_varint(input logic [63:0] v, input int pad);
      logic [63:0] rest;
      rest = v;
      while (rest > 64'h7F) begin
         body_q.push_back({1'b1, rest[6:0]});
         rest = rest >> 7;
      end
      if (pad == 0) begin
         body_q.push_back({1'b0, rest[6:0]});
      end else begin
         body_q.push_back({1'b1, rest[6:0]});
         repeat (pad - 1) body_q.push_back(8'h80);
         body_q.push_back(8'h00);
      end
   endtask

   task automatic push_tag(input logic [63:0] num, input logic [2:0] wire_type);
      push_varint({num[60:0], wire_type}, pad_choice());
   endtask

   task automatic push_random(input int n);
      repeat (n) body_q.push_back(8'($urandom));
   endtask

   task automatic add_field(input field_kind_e fk);
      int         n;
      int         w;
      logic [2:0] wire_type;
      case (fk)
         FK_VARINT: begin
            push_tag(pick_num(), WIRE_VARINT);
            push_varint({$urandom, $urandom} >> $urandom_range(0, 63), pad_choice());
         end
         FK_TRACKED, FK_OTHER: begin
            push_tag((fk == FK_TRACKED) ? tracked_num() : pick_num(), WIRE_LENGTH);
            n = $urandom_range(0, 6);
            push_varint(64'(n), pad_choice());
            push_random(n);
         end
         FK_BAD_WIRE: begin
            w = $urandom_range(0, 5);
            wire_type = (w == 0) ? 3'd1 : 3'(w + 2);
            push_tag(pick_num(), wire_type);
            push_random($urandom_range(0, 3));
         end
         FK_LONG_VARINT: begin
            // overlong tag, value or length
            case ($urandom_range(0, 2))
               0:       push_tag(pick_num(), WIRE_VARINT);
               1:       push_tag(tracked_num(), WIRE_LENGTH);
               default: ;
            endcase
            repeat (10) body_q.push_back({1'b1, 7'($urandom)});
            push_random($urandom_range(0, 2));
         end
         default: begin
            push_tag(tracked_num(), WIRE_LENGTH);
            if ($urandom_range(0, 1) == 0)
               push_varint(64'($urandom_range(120, 4000)), 0);
            else
               push_varint({$urandom, $urandom} | 64'h8000_0000, 0);
            push_random($urandom_range(0, 3));
         end
      endcase
   endtask

   // Build one frame into frame_q: mostly well formed, some broken, some header noise
   task automatic build_frame();
      int          sel;
      int          n_fields;
      int          bad_pos;
      int          r;
      int          n;
      int          cut;
      bit          body_follows;
      logic [31:0] hdr;
      frame_q.delete();
      body_q.delete();
      body_follows = 1'b0;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
         hdr = {8'($urandom_range(5, 255)), 24'($urandom)};
      end else if (sel == 1) begin
         hdr = 32'(limit_shadow) + $urandom_range(1, 3);
      end else if (sel == 2) begin
         hdr = 32'd0;
      end else begin
         n_fields = $urandom_range(0, 4);
         bad_pos  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_fields) : -1;
         for (int i = 0; i <= n_fields; i++) begin
            if (i == bad_pos) add_field(field_kind_e'(FK_BAD_WIRE + $urandom_range(0, 2)));
            if (i == n_fields) break;
            r = $urandom_range(0, 8);
            add_field((r < 3) ? FK_VARINT : (r < 7) ? FK_TRACKED : FK_OTHER);
         end
         // closing payload: missing, empty, or with content
         r = $urandom_range(0, 9);
         if (r != 0) begin
            n = (r == 1) ? 0 : $urandom_range(1, 4);
            push_tag(64'd6, WIRE_LENGTH);
            push_varint(64'(n), pad_choice());
            push_random(n);
         end
         // truncated body
         if ($urandom_range(0, 9) == 0 && body_q.size() > 1) begin
            cut = $urandom_range(1, body_q.size() - 1);
            while (body_q.size() > cut) void'(body_q.pop_back());
         end
         hdr = body_q.size();
         body_follows = (hdr <= limit_shadow);
      end
      for (int i = 3; i >= 0; i--) frame_q.push_back(hdr[i*8 +: 8]);
      if (body_follows) foreach (body_q[i]) frame_q.push_back(body_q[i]);
      frames_sent++;
   endtask

   initial begin : stimulus
      logic [FRAME_LEN_W-1:0] setting;
      int                     target;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset limit
      idle_on = 1'b1;
      for (int i = 19; i >= 0; i--) send_byte(DIRECTED_BYTES[i*8 +: 8]);
      frames_sent += 4;

      // Random frames under a series of limits; the last setting runs without idling
      for (int p = 0; p < N_SETTINGS; p++) begin
         settle();
         case (p)
            0:       setting = MAX_FRAME_LENGTH_RESET;
            1:       setting = '0;
            2:       setting = 27'd7;
            3:       setting = 27'd24;
            4:       setting = 27'($urandom_range(8, 80));
            5:       setting = 27'($urandom_range(0, 67108864));
            default: setting = MAX_FRAME_LENGTH_RESET;
         endcase
         write_limit(setting);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            idle_on = (p < N_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
            build_frame();
            send_queue();
         end
      end

      idle_on = 1'b0;
      settle();
      repeat (20) @(negedge clock);

      $display("stimulus: %0d frames, %0d bytes, %0d limit settings incl. 0 and 2^26",
               frames_sent, bytes_sent, N_SETTINGS);
      $display("checked: %0d field bytes, %0d accepts, %0d rejects; %0d failures",
               field_results, accept_results, reject_results, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/lfvp_pkg.sv
rtl/core/lfvp_parser.sv
rtl/core/lfvp_rsp_queue.sv
rtl/core/length_framed_varint_field_parser_unit.sv
tb/sv/lfvp_result_checker.sv
tb/sv/length_framed_varint_field_parser_unit_test.sv
